// ===== hdl/gclw_pkg.sv =====
package gclw_pkg;

    localparam int COORD_W = 6;
    localparam int GRID_SIZE_DEF = 64;
    localparam int ERR_W = COORD_W + 3;
    localparam int S_DATA_W = 4 * COORD_W;
    localparam int M_DATA_W = ((2 * COORD_W + 7) / 8) * 8;

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic same;
        logic at_end;
    } sts_t;

endpackage

// ===== hdl/gclw_ctrl.sv =====
module gclw_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  gclw_pkg::sts_t sts,
    output gclw_pkg::cmd_t cmd
);
    import gclw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   space;

    assign space = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !sts.same)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (space && sts.at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_WALK:
            begin
                cmd.step = space;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== hdl/gclw_dp.sv =====
module gclw_dp
#(
    parameter int GRID_SIZE = gclw_pkg::GRID_SIZE_DEF
)
(
    input  logic                            clk,
    input  logic [gclw_pkg::S_DATA_W-1:0]   s_tdata,
    output logic [gclw_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  gclw_pkg::cmd_t                  cmd,
    output gclw_pkg::sts_t                  sts
);
    import gclw_pkg::*;

    localparam coord_t CMAX = COORD_W'(GRID_SIZE - 1);

    coord_t in_sx;
    coord_t in_sy;
    coord_t in_ex;
    coord_t in_ey;
    coord_t cx_reg;
    coord_t cy_reg;
    coord_t ex_reg;
    coord_t ey_reg;
    coord_t dx_reg;
    coord_t dy_reg;
    logic   sx_reg;
    logic   sy_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;
    logic signed [ERR_W-1:0] dx_s;
    logic signed [ERR_W-1:0] dy_s;
    logic signed [ERR_W:0]   e2;
    logic   step_x;
    logic   step_y;
    coord_t cx_next;
    coord_t cy_next;
    coord_t out_x_reg;
    coord_t out_y_reg;
    logic   out_last_reg;

    function automatic coord_t clamp(input coord_t v);
        coord_t r;
        r = (v > CMAX) ? CMAX : v;
        return r;
    endfunction

    assign in_sx = clamp(s_tdata[COORD_W-1:0]);
    assign in_sy = clamp(s_tdata[2*COORD_W-1:COORD_W]);
    assign in_ex = clamp(s_tdata[3*COORD_W-1:2*COORD_W]);
    assign in_ey = clamp(s_tdata[4*COORD_W-1:3*COORD_W]);

    assign dx_s = $signed({{(ERR_W-COORD_W){1'b0}}, dx_reg});
    assign dy_s = $signed({{(ERR_W-COORD_W){1'b0}}, dy_reg});
    assign e2   = {err_reg, 1'b0};

    always_comb
    begin
        step_x   = e2 > -$signed({dy_s[ERR_W-1], dy_s});
        step_y   = e2 < $signed({dx_s[ERR_W-1], dx_s});
        err_next = err_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        if (step_x)
        begin
            err_next = err_next - dy_s;
            cx_next  = sx_reg ? cx_reg + coord_t'(1) : cx_reg - coord_t'(1);
        end
        if (step_y)
        begin
            err_next = err_next + dx_s;
            cy_next  = sy_reg ? cy_reg + coord_t'(1) : cy_reg - coord_t'(1);
        end
    end

    assign sts.same   = (in_sx == in_ex) && (in_sy == in_ey);
    assign sts.at_end = (cx_next == ex_reg) && (cy_next == ey_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg  <= in_sx;
            cy_reg  <= in_sy;
            ex_reg  <= in_ex;
            ey_reg  <= in_ey;
            sx_reg  <= in_ex > in_sx;
            sy_reg  <= in_ey > in_sy;
            dx_reg  <= (in_ex > in_sx) ? in_ex - in_sx : in_sx - in_ex;
            dy_reg  <= (in_ey > in_sy) ? in_ey - in_sy : in_sy - in_ey;
            err_reg <= $signed({{(ERR_W-COORD_W){1'b0}},
                                (in_ex > in_sx) ? in_ex - in_sx : in_sx - in_ex})
                     - $signed({{(ERR_W-COORD_W){1'b0}},
                                (in_ey > in_sy) ? in_ey - in_sy : in_sy - in_ey});
        end
        else if (cmd.step)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            err_reg <= err_next;
        end
        if (cmd.step)
        begin
            out_x_reg    <= cx_next;
            out_y_reg    <= cy_next;
            out_last_reg <= sts.at_end;
        end
    end

    assign m_tdata = {{(M_DATA_W-2*COORD_W){1'b0}}, out_y_reg, out_x_reg};
    assign m_tlast = out_last_reg;

endmodule

// ===== hdl/grid_line_cell_walker.sv =====
// Walks the line from a start cell to an end cell and emits each visited cell after the start.
// An accepted request loads the walk registers; each step then registers one cell for output.
// Throughput: one cell per cycle; a new request is taken only after the walk returns to idle.
// The single error-update stage sets the rate and a stalled cell holds the walk.
// Reset clears the controller and the output valid flag; coordinate registers are not reset.
module grid_line_cell_walker
#(
    parameter int GRID_SIZE = gclw_pkg::GRID_SIZE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [gclw_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_x, cell_y, zero padding
    output logic [gclw_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import gclw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gclw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gclw_dp #(.GRID_SIZE(GRID_SIZE)) u_dp
    (
        .clk     (clk),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// ===== hdl/gclw_chk.sv =====
module gclw_chk
#(
    parameter int GRID_SIZE = gclw_pkg::GRID_SIZE_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gclw_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gclw_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import gclw_pkg::*;

    localparam coord_t CMAX = COORD_W'(GRID_SIZE - 1);

    logic in_grid;
    logic same;

    assign in_grid = (s_tdata[COORD_W-1:0] <= CMAX)
                  && (s_tdata[2*COORD_W-1:COORD_W] <= CMAX)
                  && (s_tdata[3*COORD_W-1:2*COORD_W] <= CMAX)
                  && (s_tdata[4*COORD_W-1:3*COORD_W] <= CMAX);
    assign same = (s_tdata[COORD_W-1:0] == s_tdata[3*COORD_W-1:2*COORD_W])
               && (s_tdata[2*COORD_W-1:COORD_W] == s_tdata[4*COORD_W-1:3*COORD_W]);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && same |=> s_tready)
        else $error("empty line left the block busy");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && in_grid && !same |=> !s_tready)
        else $error("walk did not start");

    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a walk");

endmodule

bind grid_line_cell_walker gclw_chk #(.GRID_SIZE(GRID_SIZE)) u_gclw_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb_grid_line_cell_walker.sv =====
module tb_grid_line_cell_walker;

    timeunit 1ns;
    timeprecision 1ps;

    import gclw_pkg::*;

    localparam int GRID_N = 64;
    localparam int RANDOM_REQUESTS = 400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER = 120;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DIRECTED_N = 24;

    class line_walk_scoreboard;

        typedef struct {
            coord_t x;
            coord_t y;
            logic   last;
        } cell_t;

        cell_t pending_cells[$];
        int    failures = 0;

        function int clip_coord(coord_t v);
            return (int'(v) > GRID_N - 1) ? GRID_N - 1 : int'(v);
        endfunction

        function void trace_line(coord_t sx0, coord_t sy0, coord_t ex0, coord_t ey0);
            int    cx;
            int    cy;
            int    ex;
            int    ey;
            int    dx;
            int    dy;
            int    stx;
            int    sty;
            int    err;
            int    e2;
            int    steps;
            cell_t c;
            cx = clip_coord(sx0);
            cy = clip_coord(sy0);
            ex = clip_coord(ex0);
            ey = clip_coord(ey0);
            dx = (ex > cx) ? ex - cx : cx - ex;
            dy = (ey > cy) ? ey - cy : cy - ey;
            stx = (ex > cx) ? 1 : -1;
            sty = (ey > cy) ? 1 : -1;
            err = dx - dy;
            steps = 0;
            while ((cx != ex || cy != ey) && steps < GRID_N)
            begin
                e2 = 2 * err;
                if (e2 > -dy)
                begin
                    err -= dy;
                    cx += stx;
                end
                if (e2 < dx)
                begin
                    err += dx;
                    cy += sty;
                end
                c.x = coord_t'(cx);
                c.y = coord_t'(cy);
                c.last = (cx == ex && cy == ey);
                pending_cells.insert(pending_cells.size(), c);
                steps++;
            end
        endfunction

        function void check_cell(coord_t x, coord_t y, logic last);
            cell_t want;
            if (pending_cells.size() == 0)
            begin
                $display("%0t: unexpected cell x=%0d y=%0d last=%0b", $time, x, y, last);
                failures++;
                return;
            end
            want = pending_cells.pop_front();
            if (x !== want.x)
            begin
                $display("%0t: cell_x expected %0d actual %0d", $time, want.x, x);
                failures++;
            end
            if (y !== want.y)
            begin
                $display("%0t: cell_y expected %0d actual %0d", $time, want.y, y);
                failures++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                failures++;
            end
        endfunction

    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    line_walk_scoreboard board = new;
    int                  requests_taken = 0;
    int                  cycle_count = 0;
    bit                  quiet_stretch = 1'b0;

    int directed_lines [DIRECTED_N][4] = '{
        '{5, 5, 5, 5},
        '{0, 0, 0, 0},
        '{63, 63, 63, 63},
        '{0, 0, 63, 63},
        '{63, 63, 0, 0},
        '{0, 63, 63, 0},
        '{63, 0, 0, 63},
        '{0, 0, 63, 0},
        '{63, 10, 0, 10},
        '{7, 0, 7, 63},
        '{63, 63, 63, 0},
        '{0, 0, 63, 1},
        '{0, 0, 1, 63},
        '{10, 10, 11, 10},
        '{10, 10, 10, 9},
        '{10, 10, 9, 11},
        '{32, 32, 0, 17},
        '{32, 32, 17, 0},
        '{32, 32, 63, 50},
        '{32, 32, 50, 63},
        '{32, 32, 13, 63},
        '{32, 32, 63, 13},
        '{42, 21, 21, 42},
        '{21, 42, 42, 21}
    };

    grid_line_cell_walker #(
        .GRID_SIZE(GRID_N)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                board.trace_line(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W],
                                 s_tdata[3*COORD_W-1:2*COORD_W],
                                 s_tdata[4*COORD_W-1:3*COORD_W]);
                requests_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                board.check_cell(m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W], m_tlast);
            end
        end
    end

    // The receiver stalls once for a long stretch so that a walk backs up into the request side.
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held && requests_taken >= HOLD_OFF_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= quiet_stretch || ($urandom_range(99) >= 15);
            end
        end
    end

    task automatic offer_request(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        while (!quiet_stretch && $urandom_range(99) < 15)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {ey, ex, sy, sx};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int     pick;
        int     tx;
        int     ty;
        int     span;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            offer_request(coord_t'(directed_lines[i][0]), coord_t'(directed_lines[i][1]),
                          coord_t'(directed_lines[i][2]), coord_t'(directed_lines[i][3]));
        end

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            quiet_stretch = (i >= 230 && i < 320);
            pick = $urandom_range(99);
            sx = coord_t'($urandom_range(GRID_N - 1));
            sy = coord_t'($urandom_range(GRID_N - 1));
            ex = coord_t'($urandom_range(GRID_N - 1));
            ey = coord_t'($urandom_range(GRID_N - 1));
            if (pick >= 60 && pick < 80)
            begin
                tx = int'(sx) + int'($urandom_range(8)) - 4;
                ty = int'(sy) + int'($urandom_range(8)) - 4;
                ex = coord_t'((tx < 0) ? 0 : (tx > GRID_N - 1) ? GRID_N - 1 : tx);
                ey = coord_t'((ty < 0) ? 0 : (ty > GRID_N - 1) ? GRID_N - 1 : ty);
            end
            else if (pick >= 80 && pick < 88)
            begin
                ex = sx;
                ey = sy;
            end
            else if (pick >= 88 && pick < 94)
            begin
                if (pick[0])
                begin
                    ey = sy;
                end
                else
                begin
                    ex = sx;
                end
            end
            else if (pick >= 94)
            begin
                span = int'($urandom_range(GRID_N - 1, 1));
                tx = pick[0] ? int'(sx) + span : int'(sx) - span;
                ty = pick[1] ? int'(sy) + span : int'(sy) - span;
                ex = coord_t'((tx < 0) ? 0 : (tx > GRID_N - 1) ? GRID_N - 1 : tx);
                ey = coord_t'((ty < 0) ? 0 : (ty > GRID_N - 1) ? GRID_N - 1 : ty);
            end
            offer_request(sx, sy, ex, ey);
        end

        quiet_stretch = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (board.pending_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0 && board.pending_cells.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gclw_pkg.sv
hdl/gclw_ctrl.sv
hdl/gclw_dp.sv
hdl/grid_line_cell_walker.sv
hdl/gclw_chk.sv
test/tb_grid_line_cell_walker.sv
